### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the LU matrix inverse core.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property at every rising clock edge outside reset.
`define ASSERT_AT(lbl, clk_i, rstn_i, prop) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) prop) \
		else $error("assertion failed");
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk_i, rstn_i, cond) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk_i, rstn_i, prop)
`define ASSERT_NEVER(lbl, clk_i, rstn_i, cond)
`endif
`endif

### rtl/core/lumi_pkg.sv
// Shared types for the LU matrix inverse core.
// Used by the divider and the top level; depends on nothing.
`default_nettype none
package lumi_pkg;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned ORDER_W = 4;

	typedef logic signed [DATA_W-1:0] q_t;

	typedef struct packed {
		logic start;
		q_t   num;
		q_t   den;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		q_t   quot;
		logic clip;
		logic zero;
	} div_rsp_t;
endpackage
`default_nettype wire

### rtl/core/lumi_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module lumi_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wen,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wen) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

### rtl/core/lumi_div.sv
// Bit-serial signed fixed-point divider: round to nearest, ties away from zero,
// saturating to 32 bits. Depends on lumi_pkg.
`default_nettype none
module lumi_div import lumi_pkg::*; #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	localparam int unsigned NW    = DATA_W + FRAC_BITS;
	localparam int unsigned CNT_W = $clog2(NW + 1);
	localparam logic [1:0] D_IDLE = 2'd0;
	localparam logic [1:0] D_RUN  = 2'd1;
	localparam logic [1:0] D_FIN  = 2'd2;

	logic [1:0]        st_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [NW-1:0]     quo_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] nd_q;
	logic              neg_q;
	logic              zero_q;
	logic              done_q;
	logic              clip_q;
	q_t                quot_q;

	logic [DATA_W-1:0] na;
	logic [DATA_W-1:0] nd;
	logic [DATA_W:0]   trial;
	logic [DATA_W:0]   diff;
	logic              ge;
	logic              over;
	logic [DATA_W-1:0] val;

	assign na    = req.num[DATA_W-1] ? (~req.num + 1'b1) : req.num;
	assign nd    = req.den[DATA_W-1] ? (~req.den + 1'b1) : req.den;
	assign trial = {rem_q, quo_q[NW-1]};
	assign diff  = trial - {1'b0, nd_q};
	assign ge    = trial >= {1'b0, nd_q};
	assign over  = neg_q ? (quo_q > {{(NW-DATA_W){1'b0}}, 32'h8000_0000})
	                     : (quo_q > {{(NW-DATA_W){1'b0}}, 32'h7FFF_FFFF});
	assign val   = neg_q ? (~quo_q[DATA_W-1:0] + 1'b1) : quo_q[DATA_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= D_IDLE;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				D_IDLE: begin
					if (req.start) begin
						quo_q  <= {na, {FRAC_BITS{1'b0}}} + {{(NW-DATA_W+1){1'b0}}, nd[DATA_W-1:1]};
						rem_q  <= '0;
						nd_q   <= nd;
						neg_q  <= req.num[DATA_W-1] ^ req.den[DATA_W-1];
						zero_q <= (req.den == '0);
						cnt_q  <= CNT_W'(NW);
						st_q   <= D_RUN;
					end
				end
				D_RUN: begin
					rem_q <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
					quo_q <= {quo_q[NW-2:0], ge};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						st_q <= D_FIN;
					end
				end
				D_FIN: begin
					done_q <= 1'b1;
					clip_q <= over && !zero_q;
					if (zero_q) begin
						quot_q <= '0;
					end else if (over) begin
						quot_q <= neg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
					end else begin
						quot_q <= val;
					end
					st_q <= D_IDLE;
				end
				default: st_q <= D_IDLE;
			endcase
		end
	end

	assign rsp.busy = (st_q != D_IDLE);
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.clip = clip_q;
	assign rsp.zero = zero_q;
endmodule
`default_nettype wire

### rtl/core/lu_matrix_inverse_core.sv
// LU matrix inverse core, top level: sequencer, shared multiply-accumulate,
// work RAM (lumi_ram) and serial divider (lumi_div). Depends on lumi_pkg.
//
// Usage: write the order n on the cfg channel (cfg_valid/cfg_ready/cfg_data)
// while the block waits for elements; it resets to 3, 0 acts as 1 and values
// above MAX_ORDER act as MAX_ORDER. A write drops any partly loaded matrix,
// and s_tready stays low while cfg_valid is high so no element is lost.
// Send n*n signed Q16.16 elements row-major on s_tvalid/s_tready/s_tdata, one
// request per cycle while cfg_valid is low. After the last one s_tready falls
// and the block inverts the matrix in place (Crout LU, inverse of L, inverse
// of U, product). Each element passes S_START and S_BASE, runs each product
// term through S_RDA, S_RDB, S_MUL and S_ACC on the single multiplier, and in
// S_FIN is stored or sent to the bit-serial divider. The n*n results then
// leave on m_tvalid/m_tready/m_tdata with m_tlast on the final one and m_tuser
// carrying the singular and saturated flags; each result is read, loaded into
// the output register and held there before the next one is read.
// A stalled result holds in the output register until m_tready; no further
// element is taken until the last result is gone. Reset (arst_n low) returns
// the block to loading, order 3, flags clear; the RAM needs no clearing.
`default_nettype none
`include "assert_macros.svh"
module lu_matrix_inverse_core import lumi_pkg::*; #(
	parameter int unsigned MAX_ORDER = 8,
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [ORDER_W-1:0] cfg_data,   // matrix_order[3:0]
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [DATA_W-1:0]  s_tdata,    // element[31:0]
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [DATA_W-1:0]  m_tdata,    // inverse_element[31:0]
	output logic               m_tlast,    // last_element
	output logic [1:0]         m_tuser     // singular[0], saturated[1]
);
	localparam int unsigned CW = $clog2(MAX_ORDER + 1);
	localparam int unsigned IW = $clog2(MAX_ORDER);
	localparam int unsigned AW = 2 * IW;
	localparam logic [CW-1:0] ONE_C = CW'(1);
	localparam logic [CW-1:0] TWO_C = CW'(2);
	localparam logic signed [63:0] ONE_Q = 64'sd1 <<< FRAC_BITS;
	localparam logic signed [63:0] HALF_Q = 64'sd1 <<< (FRAC_BITS - 1);

	localparam logic [3:0] S_LOAD   = 4'd0;
	localparam logic [3:0] S_START  = 4'd1;
	localparam logic [3:0] S_BASE   = 4'd2;
	localparam logic [3:0] S_RDA    = 4'd3;
	localparam logic [3:0] S_RDB    = 4'd4;
	localparam logic [3:0] S_MUL    = 4'd5;
	localparam logic [3:0] S_ACC    = 4'd6;
	localparam logic [3:0] S_FIN    = 4'd7;
	localparam logic [3:0] S_DIVST  = 4'd8;
	localparam logic [3:0] S_DIVW   = 4'd9;
	localparam logic [3:0] S_OUT_RD = 4'd10;
	localparam logic [3:0] S_OUT_LD = 4'd11;
	localparam logic [3:0] S_OUT_WT = 4'd12;

	localparam logic [2:0] PH_RECIP = 3'd0;
	localparam logic [2:0] PH_ROW0  = 3'd1;
	localparam logic [2:0] PH_LCOL  = 3'd2;
	localparam logic [2:0] PH_UROW  = 3'd3;
	localparam logic [2:0] PH_LINV  = 3'd4;
	localparam logic [2:0] PH_UINV  = 3'd5;
	localparam logic [2:0] PH_MUL   = 3'd6;

	localparam logic [1:0] IN_ZERO = 2'd0;
	localparam logic [1:0] IN_ONE  = 2'd1;
	localparam logic [1:0] IN_TGT  = 2'd2;

	function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] r, input logic [CW-1:0] c);
		return {r[IW-1:0], c[IW-1:0]};
	endfunction

	logic [3:0]         state_q;
	logic [2:0]         phase_q;
	logic [ORDER_W-1:0] order_q;
	logic [CW-1:0]      row_q, col_q, i_q, j_q, k_q;
	logic               sat_q, sing_q;
	logic signed [63:0] acc_q, base_q, prod_s1;
	q_t                 a_q, num_q;
	logic [DATA_W-1:0]  m_data_q;
	logic               m_valid_q, m_last_q;

	logic [4:0]    ord5, n5;
	logic [CW-1:0] n, nm1;
	logic          s_acc, cfg_acc;

	// effective order: zero acts as one, clip at MAX_ORDER
	assign ord5 = {1'b0, order_q};
	assign n5   = (ord5 == 5'd0) ? 5'd1 : ((ord5 > 5'(MAX_ORDER)) ? 5'(MAX_ORDER) : ord5);
	assign n    = n5[CW-1:0];
	assign nm1  = n - ONE_C;

	// hold elements off while an order write is offered
	assign cfg_ready = (state_q == S_LOAD);
	assign s_tready  = (state_q == S_LOAD) && !cfg_valid;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign s_acc     = s_tvalid && s_tready;

	// element decode: target, initial value, term range and operands
	logic [CW-1:0] tgt_r, tgt_c, dv_r, dv_c, a_r, a_c, b_r, b_c, kb, ke;
	logic [1:0]    init_sel;
	logic          neg, is_div, plain;

	always_comb begin
		tgt_r = '0; tgt_c = '0; dv_r = '0; dv_c = '0;
		a_r = '0; a_c = '0; b_r = '0; b_c = '0; kb = '0; ke = '0;
		init_sel = IN_ZERO; neg = 1'b0; is_div = 1'b0; plain = 1'b0;
		case (phase_q)
			PH_RECIP: begin
				init_sel = IN_ONE; is_div = 1'b1;
			end
			PH_ROW0: begin
				tgt_c = i_q; init_sel = IN_TGT; is_div = 1'b1;
			end
			PH_LCOL: begin
				tgt_r = j_q; tgt_c = i_q; init_sel = IN_TGT; neg = 1'b1; ke = i_q;
				a_r = j_q; a_c = k_q; b_r = k_q; b_c = i_q;
			end
			PH_UROW: begin
				tgt_r = i_q; tgt_c = j_q; init_sel = IN_TGT; neg = 1'b1; ke = i_q;
				a_r = i_q; a_c = k_q; b_r = k_q; b_c = j_q;
				is_div = 1'b1; dv_r = i_q; dv_c = i_q;
			end
			PH_LINV: begin
				tgt_r = j_q; tgt_c = i_q; neg = 1'b1; kb = i_q; ke = j_q;
				init_sel = (i_q == j_q) ? IN_ONE : IN_ZERO;
				a_r = j_q; a_c = k_q; b_r = k_q; b_c = i_q;
				is_div = 1'b1; dv_r = j_q; dv_c = j_q;
			end
			PH_UINV: begin
				tgt_r = i_q; tgt_c = j_q; neg = 1'b1; kb = i_q; ke = j_q;
				a_r = k_q; a_c = j_q; b_r = i_q; b_c = k_q;
				plain = (k_q == i_q);
			end
			PH_MUL: begin
				tgt_r = j_q; tgt_c = i_q; ke = n;
				kb = (i_q > j_q) ? i_q : j_q;
				plain = (j_q == k_q);
				a_r = plain ? k_q : j_q; a_c = plain ? i_q : k_q;
				b_r = k_q; b_c = i_q;
			end
			default: ;
		endcase
	end

	// loop advance after each element
	logic [2:0]    nx_phase;
	logic [CW-1:0] nx_i, nx_j;
	logic          nx_out;

	always_comb begin
		nx_phase = phase_q; nx_i = i_q; nx_j = j_q + ONE_C; nx_out = 1'b0;
		case (phase_q)
			PH_RECIP: nx_out = 1'b1;
			PH_ROW0: begin
				nx_i = i_q + ONE_C;
				if (i_q == nm1) begin
					nx_phase = PH_LCOL; nx_i = ONE_C; nx_j = ONE_C;
				end
			end
			PH_LCOL: begin
				if (j_q == nm1) begin
					if (i_q == nm1) begin
						nx_phase = PH_LINV; nx_i = '0; nx_j = '0;
					end else begin
						nx_phase = PH_UROW; nx_j = i_q + ONE_C;
					end
				end
			end
			PH_UROW: begin
				if (j_q == nm1) begin
					nx_phase = PH_LCOL; nx_i = i_q + ONE_C; nx_j = i_q + ONE_C;
				end
			end
			PH_LINV: begin
				if (j_q == nm1) begin
					if (i_q == nm1) begin
						nx_phase = PH_UINV; nx_i = '0; nx_j = ONE_C;
					end else begin
						nx_i = i_q + ONE_C; nx_j = i_q + ONE_C;
					end
				end
			end
			PH_UINV: begin
				if (j_q == nm1) begin
					if (i_q + TWO_C >= n) begin
						nx_phase = PH_MUL; nx_i = '0; nx_j = '0;
					end else begin
						nx_i = i_q + ONE_C; nx_j = i_q + TWO_C;
					end
				end
			end
			PH_MUL: begin
				if (j_q == nm1) begin
					nx_j = '0; nx_i = i_q + ONE_C;
					nx_out = (i_q == nm1);
				end
			end
			default: nx_out = 1'b1;
		endcase
	end

	// shared arithmetic
	logic signed [63:0] rnd, term, v_sum;
	logic               v_clip;
	q_t                 v32, rdata;
	logic [DATA_W-1:0]  ram_rdata;

	assign rdata  = ram_rdata;
	assign rnd    = (prod_s1 + HALF_Q) >>> FRAC_BITS;
	assign term   = plain ? 64'(a_q) : rnd;
	assign v_sum  = base_q + acc_q;
	assign v_clip = (v_sum > 64'sd2147483647) || (v_sum < -64'sd2147483648);
	assign v32    = v_clip ? (v_sum[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : v_sum[31:0];

	div_req_t div_req;
	div_rsp_t div_rsp;

	assign div_req.start = (state_q == S_DIVST);
	assign div_req.num   = num_q;
	assign div_req.den   = rdata;

	lumi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// work RAM ports
	logic              ram_wen;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [DATA_W-1:0] ram_wdata;
	logic              el_done;

	assign el_done = (state_q == S_FIN && !is_div) || (state_q == S_DIVW && div_rsp.done);
	assign ram_wen = s_acc || el_done;
	assign ram_waddr = (state_q == S_LOAD) ? addr_of(row_q, col_q) : addr_of(tgt_r, tgt_c);
	assign ram_wdata = (state_q == S_LOAD) ? s_tdata :
	                   ((state_q == S_FIN) ? v32 : div_rsp.quot);

	always_comb begin
		case (state_q)
			S_RDA:    ram_raddr = addr_of(a_r, a_c);
			S_RDB:    ram_raddr = addr_of(b_r, b_c);
			S_FIN:    ram_raddr = addr_of(dv_r, dv_c);
			S_OUT_RD: ram_raddr = addr_of(row_q, col_q);
			default:  ram_raddr = addr_of(tgt_r, tgt_c);
		endcase
	end

	lumi_ram #(.WIDTH(DATA_W), .DEPTH(1 << AW)) u_ram (
		.clk   (clk),
		.wen   (ram_wen),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			phase_q   <= PH_RECIP;
			order_q   <= ORDER_W'(3);
			row_q     <= '0;
			col_q     <= '0;
			i_q       <= '0;
			j_q       <= '0;
			k_q       <= '0;
			sat_q     <= 1'b0;
			sing_q    <= 1'b0;
			m_valid_q <= 1'b0;
			m_last_q  <= 1'b0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (cfg_acc) begin
						// new order: drop the partial matrix
						order_q <= cfg_data;
						row_q   <= '0;
						col_q   <= '0;
						sat_q   <= 1'b0;
						sing_q  <= 1'b0;
					end else if (s_acc) begin
						col_q <= col_q + ONE_C;
						if (col_q == nm1) begin
							col_q <= '0;
							row_q <= row_q + ONE_C;
							if (row_q == nm1) begin
								row_q   <= '0;
								state_q <= S_START;
								phase_q <= (n == ONE_C) ? PH_RECIP : PH_ROW0;
								i_q     <= (n == ONE_C) ? '0 : ONE_C;
								j_q     <= '0;
							end
						end
					end
				end
				S_START: begin
					acc_q   <= '0;
					k_q     <= kb;
					state_q <= S_BASE;
				end
				S_BASE: begin
					case (init_sel)
						IN_ONE:  base_q <= ONE_Q;
						IN_TGT:  base_q <= 64'(rdata);
						default: base_q <= '0;
					endcase
					state_q <= (k_q < ke) ? S_RDA : S_FIN;
				end
				S_RDA: state_q <= S_RDB;
				S_RDB: begin
					a_q     <= rdata;
					state_q <= S_MUL;
				end
				S_MUL: begin
					prod_s1 <= 64'(a_q) * 64'(rdata);
					state_q <= S_ACC;
				end
				S_ACC: begin
					acc_q   <= neg ? (acc_q - term) : (acc_q + term);
					k_q     <= k_q + ONE_C;
					state_q <= (k_q + ONE_C < ke) ? S_RDA : S_FIN;
				end
				S_FIN: begin
					sat_q <= sat_q | v_clip;
					if (is_div) begin
						num_q   <= v32;
						state_q <= S_DIVST;
					end else begin
						phase_q <= nx_phase;
						i_q     <= nx_i;
						j_q     <= nx_j;
						state_q <= nx_out ? S_OUT_RD : S_START;
					end
				end
				S_DIVST: state_q <= S_DIVW;
				S_DIVW: begin
					if (div_rsp.done) begin
						sat_q   <= sat_q | div_rsp.clip;
						sing_q  <= sing_q | div_rsp.zero;
						phase_q <= nx_phase;
						i_q     <= nx_i;
						j_q     <= nx_j;
						state_q <= nx_out ? S_OUT_RD : S_START;
					end
				end
				S_OUT_RD: state_q <= S_OUT_LD;
				S_OUT_LD: begin
					m_data_q  <= rdata;
					m_valid_q <= 1'b1;
					m_last_q  <= (row_q == nm1) && (col_q == nm1);
					state_q   <= S_OUT_WT;
				end
				S_OUT_WT: begin
					// hold the result until the receiver takes it
					if (m_tready) begin
						m_valid_q <= 1'b0;
						if (m_last_q) begin
							row_q   <= '0;
							col_q   <= '0;
							sat_q   <= 1'b0;
							sing_q  <= 1'b0;
							state_q <= S_LOAD;
						end else begin
							state_q <= S_OUT_RD;
							col_q   <= col_q + ONE_C;
							if (col_q == nm1) begin
								col_q <= '0;
								row_q <= row_q + ONE_C;
							end
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;
	assign m_tuser  = {sat_q, sing_q};

	`ASSERT_NEVER(a_load_while_out, clk, arst_n, s_tready && m_tvalid)
	`ASSERT_AT(a_div_owned, clk, arst_n, div_rsp.busy |-> state_q == S_DIVW)
	`ASSERT_AT(a_div_idle_start, clk, arst_n, div_req.start |-> !div_rsp.busy)
	`ASSERT_AT(a_back_to_load, clk, arst_n, m_tvalid && m_tready && m_tlast |=> cfg_ready)
endmodule
`default_nettype wire
